// ----- sv/gnig_pkg.sv -----
// Shared types, constants and direction codes for the grid neighbor index generator.
`default_nettype none

package gnig_pkg;

  localparam int IDX_W = 24;
  localparam int CFG_DIM_W = 13;
  localparam int CFG_IDX_W = 2;
  localparam int NUM_DIRS = 8;
  localparam int DIR_W = 3;

  localparam int MAX_WIDTH_DEF = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;

  localparam logic [CFG_DIM_W-1:0] CFG_DIM_RESET = 13'd4096;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CONNECTIVITY = 2'd2;

  localparam logic [DIR_W-1:0] DIR_LEFT = 3'd0;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd1;
  localparam logic [DIR_W-1:0] DIR_UP = 3'd2;
  localparam logic [DIR_W-1:0] DIR_DOWN = 3'd3;
  localparam logic [DIR_W-1:0] DIR_UP_LEFT = 3'd4;
  localparam logic [DIR_W-1:0] DIR_UP_RIGHT = 3'd5;
  localparam logic [DIR_W-1:0] DIR_DOWN_LEFT = 3'd6;
  localparam logic [DIR_W-1:0] DIR_DOWN_RIGHT = 3'd7;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // One classified pixel: its index and the set of neighbors that exist.
  typedef struct packed {
    logic [IDX_W-1:0]    pixel;
    logic [NUM_DIRS-1:0] mask;
  } entry_t;

endpackage

`default_nettype wire

// ----- sv/gnig_front.sv -----
// Front end: accepts pixel indices, splits them into column and row, classifies neighbors.
`default_nettype none

module gnig_front #(
  parameter int MAX_WIDTH = gnig_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = gnig_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              push,
  input  wire logic [gnig_pkg::IDX_W-1:0]        pixel_index,
  output logic                                   full,
  input  wire logic [$clog2(MAX_WIDTH+1)-1:0]    dim_w,
  input  wire logic [$clog2(MAX_HEIGHT+1)-1:0]   dim_h,
  input  wire logic                              six_mode,
  input  wire logic                              q_full,
  output logic                                   q_push,
  output gnig_pkg::entry_t                       q_entry
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int PRW = WW + HW;
  localparam int CMPW = (PRW > gnig_pkg::IDX_W) ? PRW : gnig_pkg::IDX_W;
  localparam int QW = $clog2(MAX_HEIGHT);
  localparam int QN = (QW + 1) / 2;
  localparam int QB = 2 * QN;
  localparam int SW = (WW + QB > gnig_pkg::IDX_W) ? WW + QB : gnig_pkg::IDX_W;
  localparam int CNTW = $clog2(QN + 1);
  localparam int XW = WW + 1;
  localparam int YW = ((QB > HW) ? QB : HW) + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_CLASS
  } state_t;

  state_t                       state;
  logic [gnig_pkg::IDX_W-1:0]   pix;
  logic [PRW-1:0]               area;
  logic [SW-1:0]                rem;
  logic [SW-1:0]                dvs;
  logic [QB-1:0]                quo;
  logic [CNTW-1:0]              cnt;

  logic                         accept;
  logic [SW-1:0]                dvs_half;
  logic                         bit_hi;
  logic                         bit_lo;
  logic [SW-1:0]                rem_mid;
  logic [SW-1:0]                rem_next;

  logic [WW-1:0]                col;
  logic                         in_range;
  logic                         has_l;
  logic                         has_r;
  logic                         has_u;
  logic                         has_d;
  logic                         diag_all;
  logic                         near_diag;

  assign q_push = (state == ST_CLASS) && !q_full;
  assign full = !((state == ST_IDLE) || q_push);
  assign accept = push && !full;

  // Two quotient bits per cycle by shifted-divisor restoring division.
  always_comb begin
    dvs_half = dvs >> 1;
    bit_hi = (rem >= dvs);
    rem_mid = bit_hi ? (rem - dvs) : rem;
    bit_lo = (rem_mid >= dvs_half);
    rem_next = bit_lo ? (rem_mid - dvs_half) : rem_mid;
  end

  always_comb begin
    col = rem[WW-1:0];
    in_range = (CMPW'(pix) < CMPW'(area));
    has_l = (col != '0);
    has_r = ((XW'(col) + XW'(1)) < XW'(dim_w));
    has_u = (quo != '0);
    has_d = ((YW'(quo) + YW'(1)) < YW'(dim_h));
    diag_all = !six_mode && !(col[0] ^ quo[0]);
    near_diag = diag_all || six_mode;
    q_entry.pixel = pix;
    q_entry.mask = '0;
    if (in_range) begin
      q_entry.mask[gnig_pkg::DIR_LEFT] = has_l;
      q_entry.mask[gnig_pkg::DIR_RIGHT] = has_r;
      q_entry.mask[gnig_pkg::DIR_UP] = has_u;
      q_entry.mask[gnig_pkg::DIR_DOWN] = has_d;
      q_entry.mask[gnig_pkg::DIR_UP_LEFT] = near_diag && has_l && has_u;
      q_entry.mask[gnig_pkg::DIR_UP_RIGHT] = diag_all && has_r && has_u;
      q_entry.mask[gnig_pkg::DIR_DOWN_LEFT] = diag_all && has_l && has_d;
      q_entry.mask[gnig_pkg::DIR_DOWN_RIGHT] = near_diag && has_r && has_d;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix <= pixel_index;
      area <= PRW'(dim_w) * PRW'(dim_h);
      rem <= SW'(pixel_index);
      dvs <= SW'(dim_w) << (QB - 1);
      quo <= '0;
      cnt <= CNTW'(QN);
    end else if (state == ST_DIV) begin
      rem <= rem_next;
      dvs <= dvs >> 2;
      quo <= QB'({quo, bit_hi, bit_lo});
      cnt <= cnt - CNTW'(1);
    end
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (cnt == CNTW'(1)) begin
            state <= ST_CLASS;
          end
        end
        ST_CLASS: begin
          if (accept) begin
            state <= ST_DIV;
          end else if (q_push) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- sv/gnig_queue.sv -----
// Short queue of classified pixels between the front end and the result emitter.
`default_nettype none

module gnig_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr_en,
  input  wire gnig_pkg::entry_t  wr_entry,
  output logic                   q_full,
  input  wire logic              rd_en,
  output gnig_pkg::entry_t       rd_entry,
  output logic                   rd_valid
);

  gnig_pkg::entry_t                      slots [gnig_pkg::QUEUE_DEPTH];
  logic [gnig_pkg::QUEUE_PTR_W-1:0]      wr_ptr;
  logic [gnig_pkg::QUEUE_PTR_W-1:0]      rd_ptr;
  logic [gnig_pkg::QUEUE_CNT_W-1:0]      count;
  logic                                  do_wr;
  logic                                  do_rd;

  assign q_full = (count == gnig_pkg::QUEUE_CNT_W'(gnig_pkg::QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_entry = slots[rd_ptr];
  assign do_wr = wr_en && !q_full;
  assign do_rd = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_entry;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + gnig_pkg::QUEUE_PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + gnig_pkg::QUEUE_PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + gnig_pkg::QUEUE_CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - gnig_pkg::QUEUE_CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/gnig_back.sv -----
// Back end: emits a result per neighbor of each pixel, or one empty result if none.
`default_nettype none

module gnig_back #(
  parameter int MAX_WIDTH = gnig_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire gnig_pkg::entry_t                 head,
  input  wire logic                             head_valid,
  output logic                                  head_pop,
  input  wire logic [$clog2(MAX_WIDTH+1)-1:0]   dim_w,
  output logic                                  empty,
  input  wire logic                             pop,
  output logic [gnig_pkg::IDX_W-1:0]            neighbor_index,
  output logic [gnig_pkg::DIR_W-1:0]            direction,
  output logic                                  empty_res,
  output logic                                  last
);

  logic                               out_valid;
  logic [gnig_pkg::NUM_DIRS-1:0]      done;
  logic [gnig_pkg::NUM_DIRS-1:0]      remaining;
  logic [gnig_pkg::NUM_DIRS-1:0]      sel_bit;
  logic [gnig_pkg::NUM_DIRS-1:0]      rest;
  logic [gnig_pkg::DIR_W-1:0]         sel;
  logic                               advance;
  logic                               no_neighbor;
  logic                               final_one;
  logic [gnig_pkg::IDX_W-1:0]         step_w;
  logic [gnig_pkg::IDX_W-1:0]         row_base;
  logic [gnig_pkg::IDX_W-1:0]         nb_index;

  assign empty = !out_valid;
  assign advance = head_valid && (!out_valid || pop);
  assign remaining = head.mask & ~done;
  assign no_neighbor = (head.mask == '0);

  // Lowest pending direction goes first.
  always_comb begin
    sel = gnig_pkg::DIR_LEFT;
    for (int i = gnig_pkg::NUM_DIRS - 1; i >= 0; i--) begin
      if (remaining[i]) begin
        sel = gnig_pkg::DIR_W'(i);
      end
    end
    sel_bit = gnig_pkg::NUM_DIRS'(1) << sel;
    rest = remaining & ~sel_bit;
    final_one = no_neighbor || (rest == '0);
  end

  assign head_pop = advance && final_one;

  always_comb begin
    step_w = gnig_pkg::IDX_W'(dim_w);
    unique case (sel)
      gnig_pkg::DIR_UP, gnig_pkg::DIR_UP_LEFT, gnig_pkg::DIR_UP_RIGHT: begin
        row_base = head.pixel - step_w;
      end
      gnig_pkg::DIR_DOWN, gnig_pkg::DIR_DOWN_LEFT, gnig_pkg::DIR_DOWN_RIGHT: begin
        row_base = head.pixel + step_w;
      end
      default: begin
        row_base = head.pixel;
      end
    endcase
    unique case (sel)
      gnig_pkg::DIR_LEFT, gnig_pkg::DIR_UP_LEFT, gnig_pkg::DIR_DOWN_LEFT: begin
        nb_index = row_base - gnig_pkg::IDX_W'(1);
      end
      gnig_pkg::DIR_RIGHT, gnig_pkg::DIR_UP_RIGHT, gnig_pkg::DIR_DOWN_RIGHT: begin
        nb_index = row_base + gnig_pkg::IDX_W'(1);
      end
      default: begin
        nb_index = row_base;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (no_neighbor) begin
        neighbor_index <= '0;
        direction <= gnig_pkg::DIR_LEFT;
        empty_res <= 1'b1;
        last <= 1'b1;
      end else begin
        neighbor_index <= nb_index;
        direction <= sel;
        empty_res <= 1'b0;
        last <= final_one;
      end
    end
    if (rst) begin
      out_valid <= 1'b0;
      done <= '0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        done <= final_one ? '0 : (done | sel_bit);
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/grid_neighbor_index_generator_top.sv -----
// Top level: configuration registers, front end, pixel queue and result emitter.
// A pixel is divided in the front end by a divider that retires two quotient bits per cycle,
// then classified and written to the pixel queue; its results reach the ports through the
// emitter's output register, one result per cycle while pop is held and a pixel is queued.
// The front end takes a new pixel in the cycle its previous one enters the queue, and
// stalls while the queue is full. Reset restores the defaults.
`default_nettype none

module grid_neighbor_index_generator_top #(
  parameter int MAX_WIDTH = gnig_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = gnig_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               push,
  output logic                                    full,
  input  wire logic [gnig_pkg::IDX_W-1:0]         pixel_index,
  output logic                                    empty,
  input  wire logic                               pop,
  output logic [gnig_pkg::IDX_W-1:0]              neighbor_index,
  output logic [gnig_pkg::DIR_W-1:0]              direction,
  output logic                                    empty_res,
  output logic                                    last,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [gnig_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [gnig_pkg::CFG_DIM_W-1:0]     cfg_data
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  logic [gnig_pkg::CFG_DIM_W-1:0]   grid_width;
  logic [gnig_pkg::CFG_DIM_W-1:0]   grid_height;
  logic                             connectivity;
  logic [WW-1:0]                    dim_w;
  logic [HW-1:0]                    dim_h;

  logic                             q_full;
  logic                             q_push;
  gnig_pkg::entry_t                 q_entry;
  gnig_pkg::entry_t                 head;
  logic                             head_valid;
  logic                             head_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width <= gnig_pkg::CFG_DIM_RESET;
      grid_height <= gnig_pkg::CFG_DIM_RESET;
      connectivity <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        gnig_pkg::REG_GRID_WIDTH: begin
          grid_width <= cfg_data;
        end
        gnig_pkg::REG_GRID_HEIGHT: begin
          grid_height <= cfg_data;
        end
        gnig_pkg::REG_CONNECTIVITY: begin
          connectivity <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  // A zero dimension counts as one; an oversized one saturates at its maximum.
  always_comb begin
    if (grid_width == '0) begin
      dim_w = WW'(1);
    end else if (32'(grid_width) > MAX_WIDTH) begin
      dim_w = WW'(MAX_WIDTH);
    end else begin
      dim_w = WW'(grid_width);
    end
    if (grid_height == '0) begin
      dim_h = HW'(1);
    end else if (32'(grid_height) > MAX_HEIGHT) begin
      dim_h = HW'(MAX_HEIGHT);
    end else begin
      dim_h = HW'(grid_height);
    end
  end

  gnig_front #(
    .MAX_WIDTH(MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .push(push),
    .pixel_index(pixel_index),
    .full(full),
    .dim_w(dim_w),
    .dim_h(dim_h),
    .six_mode(connectivity),
    .q_full(q_full),
    .q_push(q_push),
    .q_entry(q_entry)
  );

  gnig_queue u_queue (
    .clk(clk),
    .rst(rst),
    .wr_en(q_push),
    .wr_entry(q_entry),
    .q_full(q_full),
    .rd_en(head_pop),
    .rd_entry(head),
    .rd_valid(head_valid)
  );

  gnig_back #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .head(head),
    .head_valid(head_valid),
    .head_pop(head_pop),
    .dim_w(dim_w),
    .empty(empty),
    .pop(pop),
    .neighbor_index(neighbor_index),
    .direction(direction),
    .empty_res(empty_res),
    .last(last)
  );

endmodule

`default_nettype wire

// ----- test/grid_neighbor_checker.sv -----
// Checker for the grid neighbor index generator: predicts neighbor results and compares them.
module grid_neighbor_checker
  import gnig_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic                 full,
  input  logic [IDX_W-1:0]     pixel_index,
  input  logic                 pop,
  input  logic                 empty,
  input  logic [IDX_W-1:0]     neighbor_index,
  input  logic [DIR_W-1:0]     direction,
  input  logic                 empty_res,
  input  logic                 last,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DIM_W-1:0] cfg_data,
  output int                   fail_count,
  output int                   neighbors_due
);

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [DIR_W-1:0] dir;
    logic             no_nbr;
    logic             last;
  } neighbor_t;

  neighbor_t             expected_neighbors[$];
  logic [CFG_DIM_W-1:0]  grid_w_reg = CFG_DIM_RESET;
  logic [CFG_DIM_W-1:0]  grid_h_reg = CFG_DIM_RESET;
  logic                  six_mode = 1'b0;

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic void append_expected(input neighbor_t r);
    expected_neighbors = {expected_neighbors, r};
  endfunction

  function automatic void add_neighbor(input int unsigned n, input logic [DIR_W-1:0] d);
    neighbor_t r;
    r.idx = n[IDX_W-1:0];
    r.dir = d;
    r.no_nbr = 1'b0;
    r.last = 1'b0;
    append_expected(r);
  endfunction

  // Appends every result that one pixel transaction should produce.
  function automatic void predict_neighbors(input logic [IDX_W-1:0] pix);
    int unsigned w, h, p, x, y, first;
    bit has_l, has_r, has_u, has_d, diag;
    neighbor_t none_res;
    first = expected_neighbors.size();
    w = clamp_dim(32'(grid_w_reg), MAX_WIDTH);
    h = clamp_dim(32'(grid_h_reg), MAX_HEIGHT);
    p = 32'(pix);
    if (p < w * h) begin
      x = p % w;
      y = p / w;
      has_l = x > 0;
      has_r = x + 1 < w;
      has_u = y > 0;
      has_d = y + 1 < h;
      diag = !six_mode && ((x + y) % 2 == 0);
      if (has_l) add_neighbor(p - 1, DIR_LEFT);
      if (has_r) add_neighbor(p + 1, DIR_RIGHT);
      if (has_u) add_neighbor(p - w, DIR_UP);
      if (has_d) add_neighbor(p + w, DIR_DOWN);
      if ((diag || six_mode) && has_l && has_u) add_neighbor(p - w - 1, DIR_UP_LEFT);
      if (diag && has_r && has_u) add_neighbor(p - w + 1, DIR_UP_RIGHT);
      if (diag && has_l && has_d) add_neighbor(p + w - 1, DIR_DOWN_LEFT);
      if ((diag || six_mode) && has_r && has_d) add_neighbor(p + w + 1, DIR_DOWN_RIGHT);
    end
    if (expected_neighbors.size() == first) begin
      none_res.idx = '0;
      none_res.dir = DIR_LEFT;
      none_res.no_nbr = 1'b1;
      none_res.last = 1'b1;
      append_expected(none_res);
    end else begin
      expected_neighbors[expected_neighbors.size() - 1].last = 1'b1;
    end
  endfunction

  task automatic report_field(input string name, input logic [IDX_W-1:0] want,
                              input logic [IDX_W-1:0] got);
    $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    fail_count++;
  endtask

  always @(posedge clk) begin
    neighbor_t want;
    if (rst) begin
      expected_neighbors.delete();
      grid_w_reg = CFG_DIM_RESET;
      grid_h_reg = CFG_DIM_RESET;
      six_mode = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GRID_WIDTH: grid_w_reg = cfg_data;
          REG_GRID_HEIGHT: grid_h_reg = cfg_data;
          REG_CONNECTIVITY: six_mode = cfg_data[0];
          default: ;
        endcase
      end
      if (pop && !empty) begin
        if (expected_neighbors.size() == 0) begin
          $display("%0t: unexpected result, expected none actual index %0h dir %0d",
                   $time, neighbor_index, direction);
          fail_count++;
        end else begin
          want = expected_neighbors.pop_front();
          if (neighbor_index !== want.idx) report_field("neighbor_index", want.idx, neighbor_index);
          if (direction !== want.dir)
            report_field("direction", IDX_W'(want.dir), IDX_W'(direction));
          if (empty_res !== want.no_nbr)
            report_field("empty_res", IDX_W'(want.no_nbr), IDX_W'(empty_res));
          if (last !== want.last) report_field("last", IDX_W'(want.last), IDX_W'(last));
        end
      end
      if (push && !full) predict_neighbors(pixel_index);
    end
    neighbors_due = expected_neighbors.size();
  end

endmodule

// ----- test/tb_grid_neighbor_index_generator_top.sv -----
// Testbench top: clock, reset, stimulus, configuration phases, watchdog and verdict.
module tb_grid_neighbor_index_generator_top;
  import gnig_pkg::*;

  localparam logic CONN_CHECKERBOARD = 1'b0;
  localparam logic CONN_SIX = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 5000;

  logic                 clk;
  logic                 rst;
  logic                 push;
  logic                 full;
  logic [IDX_W-1:0]     pixel_index;
  logic                 empty;
  logic                 pop;
  logic [IDX_W-1:0]     neighbor_index;
  logic [DIR_W-1:0]     direction;
  logic                 empty_res;
  logic                 last;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DIM_W-1:0] cfg_data;
  int                   fail_count;
  int                   neighbors_due;

  int unsigned w_eff = MAX_WIDTH_DEF;
  int unsigned h_eff = MAX_HEIGHT_DEF;
  bit          steady = 1'b0;
  int          hold_requests = 0;
  int          stall_cycles = 0;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  grid_neighbor_index_generator_top i_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .pixel_index(pixel_index),
    .empty(empty), .pop(pop), .neighbor_index(neighbor_index), .direction(direction),
    .empty_res(empty_res), .last(last), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  grid_neighbor_checker i_checker (
    .clk(clk), .rst(rst), .push(push), .full(full), .pixel_index(pixel_index),
    .pop(pop), .empty(empty), .neighbor_index(neighbor_index), .direction(direction),
    .empty_res(empty_res), .last(last), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .fail_count(fail_count),
    .neighbors_due(neighbors_due)
  );

  // Leaves cfg_valid high; the caller lowers it after the last write of a group.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DIM_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic set_grid(input logic [CFG_DIM_W-1:0] w, input logic [CFG_DIM_W-1:0] h,
                          input logic conn);
    cfg_write(REG_GRID_WIDTH, w);
    cfg_write(REG_GRID_HEIGHT, h);
    cfg_write(REG_CONNECTIVITY, {{(CFG_DIM_W-1){1'b0}}, conn});
    cfg_valid <= 1'b0;
    w_eff = (w == 0) ? 1 : ((w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : w);
    h_eff = (h == 0) ? 1 : ((h > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : h);
  endtask

  // Leaves push high so back-to-back pixels need no extra edge.
  task automatic send_pixel(input logic [IDX_W-1:0] p);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push <= 1'b1;
    pixel_index <= p;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  task automatic end_burst();
    push <= 1'b0;
    while (neighbors_due != 0) @(negedge clk);
  endtask

  function automatic logic [CFG_DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 5))
      0: return CFG_DIM_W'($urandom_range(1, 4));
      1: return CFG_DIM_W'($urandom_range(1, 64));
      2: return CFG_DIM_W'($urandom_range(0, 8191));
      3: return '0;
      4: return '1;
      default: return CFG_DIM_W'($urandom_range(65, 4096));
    endcase
  endfunction

  // Mostly pixels inside the grid, biased toward its borders; the rest span all 24 bits.
  function automatic logic [IDX_W-1:0] pick_pixel();
    int unsigned x, y;
    if ($urandom_range(0, 4) == 0) return IDX_W'($urandom_range(0, 24'hFFFFFF));
    case ($urandom_range(0, 2))
      0: x = 0;
      1: x = w_eff - 1;
      default: x = $urandom_range(0, w_eff - 1);
    endcase
    case ($urandom_range(0, 2))
      0: y = 0;
      1: y = h_eff - 1;
      default: y = $urandom_range(0, h_eff - 1);
    endcase
    return IDX_W'(y * w_eff + x);
  endfunction

  initial begin
    pop = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      int gap;
      if (hold_requests != 0) begin
        hold_requests--;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      gap = steady ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL grid_neighbor_index_generator_top");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    push = 1'b0;
    pixel_index = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_GRID_WIDTH;
    cfg_data = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset geometry: corners, a border pixel, both parities inside.
    send_pixel(24'd0);
    send_pixel(24'd4095);
    send_pixel(24'd16773120);
    send_pixel(24'hFFFFFF);
    send_pixel(24'd4097);
    send_pixel(24'd4098);
    send_pixel(24'd8388608);
    end_burst();

    // Zero dimensions act as a single pixel with no neighbor.
    set_grid('0, '0, CONN_SIX);
    send_pixel(24'd0);
    send_pixel(24'd1);
    send_pixel(24'hFFFFFF);
    end_burst();

    // Oversized width saturates; two rows in six-neighbor mode.
    set_grid('1, 13'd2, CONN_SIX);
    send_pixel(24'd0);
    send_pixel(24'd4095);
    send_pixel(24'd4096);
    send_pixel(24'd8191);
    send_pixel(24'd4097);
    send_pixel(24'd8192);
    end_burst();

    // A write to the unused register index must leave the 3x3 geometry intact.
    set_grid(13'd3, 13'd3, CONN_CHECKERBOARD);
    @(negedge clk);
    cfg_write(REG_UNUSED, '1);
    cfg_valid <= 1'b0;
    for (int p = 0; p < 9; p++) send_pixel(IDX_W'(p));
    end_burst();

    for (int ph = 0; ph < 8; ph++) begin
      set_grid(pick_dim(), pick_dim(), 1'($urandom_range(0, 1)));
      steady = (ph == 1) || (ph == 5);
      // Stall the result side long enough for the block to back up into its input.
      if (ph == 1) hold_requests++;
      repeat (43) send_pixel(pick_pixel());
      end_burst();
    end

    repeat (20) @(negedge clk);
    if (fail_count == 0)
      $display("PASS grid_neighbor_index_generator_top");
    else
      $display("FAIL grid_neighbor_index_generator_top");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/gnig_pkg.sv
sv/gnig_front.sv
sv/gnig_queue.sv
sv/gnig_back.sv
sv/grid_neighbor_index_generator_top.sv
test/grid_neighbor_checker.sv
test/tb_grid_neighbor_index_generator_top.sv
